>>> rtl/core/v2n_pkg.sv
// ---------------------------------------------------------------------------
// v2n_pkg
// Types, constants and step functions shared by the vector normaliser.
// ---------------------------------------------------------------------------
package v2n_pkg;

  localparam int DIV_STEPS = 29;
  localparam int MAG_STEPS = 16;
  localparam int SQ_STEPS  = 15;
  localparam int N_STAGES  = DIV_STEPS + SQ_STEPS;

  typedef struct packed {
    logic [30:0] ax2;
    logic [30:0] ay2;
    logic [31:0] sumsq;
    logic        sx;
    logic        sy;
    logic        zero;
  } front_t;

  typedef struct packed {
    logic [31:0] rx;
    logic [31:0] ry;
    logic [28:0] qx;
    logic [28:0] qy;
    logic [31:0] d;
    logic        nlx;
    logic        nly;
    logic [31:0] mv;
    logic [31:0] mr;
    logic [31:0] svx;
    logic [31:0] srx;
    logic [31:0] svy;
    logic [31:0] sry;
    logic        sx;
    logic        sy;
    logic        zero;
  } stage_t;

  typedef struct packed {
    logic [31:0] v;
    logic [31:0] root;
  } sq_t;

  typedef struct packed {
    logic [31:0] r;
    logic [28:0] q;
  } div_t;

  function automatic sq_t sqrt_step(logic [31:0] v, logic [31:0] root, logic [31:0] bitv);
    sq_t res;
    if (v >= root + bitv) begin
      res.v    = v - (root + bitv);
      res.root = (root >> 1) + bitv;
    end else begin
      res.v    = v;
      res.root = root >> 1;
    end
    return res;
  endfunction

  function automatic div_t div_step(logic [31:0] r, logic nb, logic [31:0] d,
                                    logic [28:0] q);
    div_t       res;
    logic [32:0] t;
    t = {r, nb};
    if (t >= {1'b0, d}) begin
      t     = t - {1'b0, d};
      res.q = {q[27:0], 1'b1};
    end else begin
      res.q = {q[27:0], 1'b0};
    end
    res.r = t[31:0];
    return res;
  endfunction

endpackage

>>> rtl/core/vector2_normalize.sv
// ---------------------------------------------------------------------------
// vector2_normalize
// Length and unit vector of a Q8.8 2D vector, fully pipelined.
// ---------------------------------------------------------------------------
// channel   dir  tdata (low bit first)                       tuser
// s_axis    in   x_component[15:0], y_component[31:16]        -
// m_axis    out  unit_x[15:0], unit_y[31:16], magnitude[47:32] is_zero
//
// One item per cycle sustained while the output does not stall; path
// is 1 front stage, the two-entry queue, then 44 back stages (29
// divide bits then 15 square root bits).
// Reset clears only valid flags, queue pointers and the queue count.
// Output stall freezes the back pipeline; the queue lets the front run on.
// ---------------------------------------------------------------------------
module vector2_normalize (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // x_component, y_component
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // unit_x, unit_y, magnitude
  output logic        m_axis_tuser_o    // is_zero
);

  logic            f_valid, f_ready, q_full, q_empty, q_pop;
  v2n_pkg::front_t f_data, q_data;
  logic [15:0]     ux, uy, mag;

  v2n_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .x_i         (s_axis_tdata_i[15:0]),
    .y_i         (s_axis_tdata_i[31:16]),
    .out_valid_o (f_valid),
    .out_ready_i (f_ready),
    .out_data_o  (f_data)
  );

  assign f_ready = !q_full;

  v2n_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_valid),
    .full_o  (q_full),
    .wdata_i (f_data),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .rdata_o (q_data)
  );

  v2n_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (!q_empty),
    .in_pop_o    (q_pop),
    .in_data_i   (q_data),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .unit_x_o    (ux),
    .unit_y_o    (uy),
    .magnitude_o (mag),
    .is_zero_o   (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {mag, uy, ux};

endmodule

>>> rtl/core/v2n_front.sv
// ---------------------------------------------------------------------------
// v2n_front
// Takes items, forms absolute values, squares, sum and zero flag.
// ---------------------------------------------------------------------------
module v2n_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [15:0]     x_i,
  input  logic [15:0]     y_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output v2n_pkg::front_t out_data_o
);

  logic            v_q;
  v2n_pkg::front_t d_q, d_d;
  logic [15:0]     ax, ay;
  logic [31:0]     px, py;

  assign in_ready_o  = !v_q || out_ready_i;
  assign out_valid_o = v_q;
  assign out_data_o  = d_q;

  always_comb begin
    ax       = x_i[15] ? 16'(-x_i) : x_i;
    ay       = y_i[15] ? 16'(-y_i) : y_i;
    px       = ax * ax;
    py       = ay * ay;
    d_d.ax2   = px[30:0];
    d_d.ay2   = py[30:0];
    d_d.sumsq = px + py;
    d_d.sx    = x_i[15];
    d_d.sy    = y_i[15];
    d_d.zero  = (x_i == '0) && (y_i == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (in_ready_o) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      d_q <= d_d;
    end
  end

endmodule

>>> rtl/core/v2n_fifo.sv
// ---------------------------------------------------------------------------
// v2n_fifo
// Two-entry queue between front and back.
// ---------------------------------------------------------------------------
module v2n_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  output logic            full_o,
  input  v2n_pkg::front_t wdata_i,
  input  logic            pop_i,
  output logic            empty_o,
  output v2n_pkg::front_t rdata_o
);

  v2n_pkg::front_t mem_q [2];
  logic            wp_q, rp_q;
  logic [1:0]      cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign rdata_o = mem_q[rp_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wp_q <= !wp_q;
      if (do_pop)  rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= wdata_i;
    end
  end

endmodule

>>> rtl/core/v2n_back.sv
// ---------------------------------------------------------------------------
// v2n_back
// Pipelined restoring divide and integer square roots, one bit a stage.
// ---------------------------------------------------------------------------
module v2n_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_pop_o,
  input  v2n_pkg::front_t in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [15:0]     unit_x_o,
  output logic [15:0]     unit_y_o,
  output logic [15:0]     magnitude_o,
  output logic            is_zero_o
);

  localparam int NS = v2n_pkg::N_STAGES;

  logic            vld_q [NS];
  v2n_pkg::stage_t st_q [NS];
  v2n_pkg::stage_t st_d [NS];
  v2n_pkg::stage_t init;
  v2n_pkg::stage_t last;
  logic            en;

  assign en       = !vld_q[NS-1] || out_ready_i;
  assign in_pop_o = en;

  always_comb begin
    init      = '0;
    init.rx   = {2'b0, in_data_i.ax2[30:1]};
    init.ry   = {2'b0, in_data_i.ay2[30:1]};
    init.nlx  = in_data_i.ax2[0];
    init.nly  = in_data_i.ay2[0];
    init.d    = in_data_i.sumsq;
    init.mv   = in_data_i.sumsq;
    init.sx   = in_data_i.sx;
    init.sy   = in_data_i.sy;
    init.zero = in_data_i.zero;
  end

  for (genvar k = 0; k < NS; k++) begin : g_stage
    localparam int MB = (k < v2n_pkg::MAG_STEPS) ? 2 * (v2n_pkg::MAG_STEPS - 1 - k) : 0;
    localparam int SB = (k >= v2n_pkg::DIV_STEPS) ?
                        2 * (v2n_pkg::SQ_STEPS - 1 - (k - v2n_pkg::DIV_STEPS)) : 0;
    v2n_pkg::stage_t src;
    v2n_pkg::div_t   dx, dy;
    v2n_pkg::sq_t    sm, s1, s2;
    logic            vin;

    if (k == 0) begin : g_first
      assign src = init;
      assign vin = in_valid_i;
    end else begin : g_next
      assign src = st_q[k-1];
      assign vin = vld_q[k-1];
    end

    always_comb begin
      st_d[k] = src;
      dx = '0;
      dy = '0;
      sm = '0;
      s1 = '0;
      s2 = '0;
      if (k < v2n_pkg::DIV_STEPS) begin
        dx = v2n_pkg::div_step(src.rx, (k == 0) ? src.nlx : 1'b0, src.d, src.qx);
        dy = v2n_pkg::div_step(src.ry, (k == 0) ? src.nly : 1'b0, src.d, src.qy);
        st_d[k].rx = dx.r;
        st_d[k].ry = dy.r;
        st_d[k].qx = dx.q;
        st_d[k].qy = dy.q;
        if (k == v2n_pkg::DIV_STEPS - 1) begin
          st_d[k].svx = {3'b0, dx.q};
          st_d[k].svy = {3'b0, dy.q};
          st_d[k].srx = '0;
          st_d[k].sry = '0;
        end
      end
      if (k < v2n_pkg::MAG_STEPS) begin
        sm = v2n_pkg::sqrt_step(src.mv, src.mr, 32'(1) << MB);
        st_d[k].mv = sm.v;
        st_d[k].mr = sm.root;
      end
      if (k >= v2n_pkg::DIV_STEPS) begin
        s1 = v2n_pkg::sqrt_step(src.svx, src.srx, 32'(1) << SB);
        s2 = v2n_pkg::sqrt_step(src.svy, src.sry, 32'(1) << SB);
        st_d[k].svx = s1.v;
        st_d[k].srx = s1.root;
        st_d[k].svy = s2.v;
        st_d[k].sry = s2.root;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  assign last        = st_q[NS-1];
  assign out_valid_o = vld_q[NS-1];
  assign is_zero_o   = last.zero;
  assign magnitude_o = last.zero ? 16'd0 : last.mr[15:0];
  assign unit_x_o    = last.zero ? 16'd0 : (last.sx ? 16'(-last.srx[15:0]) : last.srx[15:0]);
  assign unit_y_o    = last.zero ? 16'd0 : (last.sy ? 16'(-last.sry[15:0]) : last.sry[15:0]);

endmodule

>>> rtl/core/v2n_checker.sv
// ---------------------------------------------------------------------------
// v2n_checker
// Port-level checks on the vector normaliser.
// ---------------------------------------------------------------------------
module v2n_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [47:0] m_axis_tdata_o,
  input logic        m_axis_tuser_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output item dropped under stall");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o == 48'd0)
    else $error("zero vector with nonzero data");

  a_mag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |->
      m_axis_tdata_o[47:32] != 16'd0 && m_axis_tdata_o[47:32] <= 16'd46341)
    else $error("magnitude out of range");

  a_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      $signed(m_axis_tdata_o[15:0]) <= 16'sd16384 &&
      $signed(m_axis_tdata_o[15:0]) >= -16'sd16384 &&
      $signed(m_axis_tdata_o[31:16]) <= 16'sd16384 &&
      $signed(m_axis_tdata_o[31:16]) >= -16'sd16384)
    else $error("unit component out of range");

endmodule

bind vector2_normalize v2n_checker u_v2n_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
